// ===== sv/assert_macros.svh =====
// assertion macros shared by the charge profile sequencer
// every macro samples on clk in the using scope; BCPS_ASSERT also expects rst_n there
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define BCPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define BCPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bcps_pkg.sv =====
// types, constants and helper functions of the charge profile sequencer
// no dependencies; used by bcps_step, battery_charge_profile_sequencer and the bench
package bcps_pkg;

  localparam int TIMER_WIDTH   = 32;
  localparam int CURRENT_WIDTH = 16;

  typedef logic [TIMER_WIDTH-1:0]   timer_t;
  typedef logic [CURRENT_WIDTH-1:0] current_t;

  // profile voltages in mV per cell
  localparam int VGAS_BASE  = 2480;
  localparam int VGAS_MAX   = 2500;
  localparam int VGAS_MIN   = 2320;
  localparam int VREQ_PH1   = 2600;
  localparam int VREQ_PH3   = 2650;
  localparam int VAVAIL_LOW = 2150;

  // profile times in seconds
  localparam int PH1_MAX_TIME  = 2 * 3600 + 30 * 60;
  localparam int PH2_MAX_TIME  = 2 * 3600 + 30 * 60;
  localparam int PH3_MAX_TIME  = 1 * 3600;
  localparam int COMP_MAX_TIME = 1 * 3600;
  localparam int DIDT_PERIOD   = 15 * 60;
  localparam int EARLY_WINDOW  = 5 * 60;
  localparam int REFRESH_WAIT  = 60;

  // currents in tenths of ampere
  localparam int DIDT_THRESHOLD = 50;
  localparam int LOW_CURRENT    = 20;
  localparam int IPH1_MIN       = 50;
  localparam int IPH3_MIN       = 5;
  localparam int CMAX           = (1 << CURRENT_WIDTH) - 1;

  // divide by 50 as multiply by ceil(2^22 / 50), exact for 16 bit operands
  localparam int DIV50_SHIFT = 22;
  localparam int DIV50_MUL   = ((1 << DIV50_SHIFT) + 49) / 50;

  typedef enum logic [3:0] {
    PH_START1    = 4'd0,
    PH_PH1       = 4'd1,
    PH_START2    = 4'd2,
    PH_PH2       = 4'd3,
    PH_START3    = 4'd4,
    PH_PH3       = 4'd5,
    PH_ENDPOINT  = 4'd6,
    PH_AVAIL     = 4'd7,
    PH_STARTCOMP = 4'd8,
    PH_COMP      = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    CFG_BAT_CAPACITY        = 3'd0,
    CFG_MAX_CURRENT         = 3'd1,
    CFG_START_TEMP          = 3'd2,
    CFG_COMP_TEMP           = 3'd3,
    CFG_VBAT_CHECK_DELAY    = 3'd4,
    CFG_CURRENT_CHECK_DELAY = 3'd5,
    CFG_PHASE3_VREG_DELAY   = 3'd6,
    CFG_COMP_MIN_CURRENT    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [11:0]        bat_capacity;
    logic [15:0]        max_current;
    logic signed [7:0]  start_temp;
    logic signed [7:0]  comp_temp;
    logic [15:0]        vbat_check_delay;
    logic [15:0]        current_check_delay;
    logic [15:0]        phase3_vreg_delay;
    logic [15:0]        comp_min_current;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        charge_seconds;
    logic [11:0]        cell_voltage;
    logic [11:0]        filtered_cell_voltage;
    logic signed [15:0] battery_current;
  } in_word_t;

  typedef struct packed {
    logic [15:0] current_request;
    logic [11:0] voltage_request;
    logic [3:0]  phase;
    logic        timeout_fault;
    logic        didt_fault;
  } out_word_t;

  // lowest dI/dt current spans the full register and current range
  typedef struct packed {
    phase_t                   phase;
    current_t                 phase1_current;
    logic [11:0]              gassing_voltage;
    timer_t                   phase1_deadline;
    timer_t                   phase2_deadline;
    timer_t                   phase3_deadline;
    timer_t                   vbat_check_deadline;
    timer_t                   current_check_deadline;
    timer_t                   phase3_vreg_deadline;
    timer_t                   didt_deadline;
    logic signed [16:0]       didt_lowest_current;
    timer_t                   refresh_mark;
    logic [15:0]              current_request;
    logic [11:0]              voltage_request;
    logic                     timeout_fault;
    logic                     didt_fault;
  } state_t;

  // deadline arithmetic wraps at the timer width
  function automatic timer_t tadd(timer_t t, timer_t d);
    return t + d;
  endfunction

  // temperature compensated gassing voltage, clamped
  function automatic logic [11:0] gas_level(logic signed [7:0] temp);
    logic signed [13:0] v;
    v = 14'(VGAS_BASE) - $signed({{4{temp[7]}}, temp, 2'b00});
    if (v > 14'(VGAS_MAX)) begin
      v = 14'(VGAS_MAX);
    end else if (v < 14'(VGAS_MIN)) begin
      v = 14'(VGAS_MIN);
    end
    return v[11:0];
  endfunction

endpackage

// ===== sv/bcps_step.sv =====
// next state logic of the charge profile for one charger tick
// depends on bcps_pkg
module bcps_step (
  input  bcps_pkg::cfg_t     cfg,
  input  bcps_pkg::state_t   state,
  input  bcps_pkg::in_word_t word,
  output bcps_pkg::state_t   state_nxt
);

  bcps_pkg::timer_t           t;
  logic signed [15:0]         ibat;
  logic [14:0]                cap_x5;
  logic [16:0]                iph1;
  logic [32:0]                div_prod;
  logic [10:0]                div_quot;
  logic signed [17:0]         didt_rise;
  logic signed [16:0]         ibat_ext;

  assign t    = word.charge_seconds[bcps_pkg::TIMER_WIDTH-1:0];
  assign ibat = word.battery_current;

  // phase 1 current: five times capacity, floor, clamp
  always_comb begin
    cap_x5 = {1'b0, cfg.bat_capacity, 2'b00} + {3'b000, cfg.bat_capacity};
    if ({2'b00, cap_x5} < 17'(bcps_pkg::IPH1_MIN)) begin
      iph1 = 17'(bcps_pkg::IPH1_MIN);
    end else if ({2'b00, cap_x5} > {1'b0, cfg.max_current}) begin
      iph1 = {1'b0, cfg.max_current};
    end else begin
      iph1 = {2'b00, cap_x5};
    end
    if (iph1 > 17'(bcps_pkg::CMAX)) begin
      iph1 = 17'(bcps_pkg::CMAX);
    end
  end

  // phase 3 current: phase 1 current over 50 by reciprocal multiply
  assign div_prod = 33'(state.phase1_current) * 33'(bcps_pkg::DIV50_MUL);
  assign div_quot = div_prod[bcps_pkg::DIV50_SHIFT +: 11];

  // current rise against lowest seen current
  assign ibat_ext  = {ibat[15], ibat};
  assign didt_rise = $signed({ibat_ext[16], ibat_ext})
                   - $signed({state.didt_lowest_current[16], state.didt_lowest_current});

  // phase sequencing
  always_comb begin
    state_nxt = state;
    unique case (state.phase)
      bcps_pkg::PH_START1: begin
        state_nxt.phase1_current      = bcps_pkg::current_t'(iph1);
        state_nxt.gassing_voltage     = bcps_pkg::gas_level(cfg.start_temp);
        state_nxt.phase1_deadline     = bcps_pkg::tadd(t,
                                        bcps_pkg::timer_t'(bcps_pkg::PH1_MAX_TIME));
        state_nxt.current_request     = 16'(iph1);
        state_nxt.voltage_request     = 12'(bcps_pkg::VREQ_PH1);
        state_nxt.vbat_check_deadline = bcps_pkg::tadd(t,
                                        bcps_pkg::timer_t'(cfg.vbat_check_delay));
        state_nxt.phase               = bcps_pkg::PH_PH1;
      end
      bcps_pkg::PH_PH1: begin
        if (t > state.phase1_deadline) begin
          state_nxt.timeout_fault = 1'b1;
          state_nxt.phase         = bcps_pkg::PH_ENDPOINT;
        end else if (word.cell_voltage >= state.gassing_voltage) begin
          if (state.vbat_check_deadline < t) begin
            state_nxt.phase = bcps_pkg::PH_START2;
          end
        end else begin
          state_nxt.vbat_check_deadline = bcps_pkg::tadd(t,
                                          bcps_pkg::timer_t'(cfg.vbat_check_delay));
        end
      end
      bcps_pkg::PH_START2: begin
        state_nxt.phase2_deadline = bcps_pkg::tadd(t,
                                    bcps_pkg::timer_t'(bcps_pkg::PH2_MAX_TIME));
        state_nxt.didt_deadline   = bcps_pkg::tadd(t,
                                    bcps_pkg::timer_t'(bcps_pkg::DIDT_PERIOD));
        state_nxt.didt_lowest_current = $signed({1'b0, cfg.max_current});
        if (state.phase1_current != '0) begin
          state_nxt.current_request = 16'(state.phase1_current - 1'b1);
        end else begin
          state_nxt.current_request = '0;
        end
        state_nxt.voltage_request        = state.gassing_voltage;
        state_nxt.current_check_deadline = bcps_pkg::tadd(t,
                                           bcps_pkg::timer_t'(cfg.current_check_delay));
        state_nxt.phase                  = bcps_pkg::PH_PH2;
      end
      bcps_pkg::PH_PH2: begin
        if (t > state.phase2_deadline) begin
          state_nxt.phase = bcps_pkg::PH_START3;
        end else if (ibat <= 16'sd20 && t < bcps_pkg::timer_t'(bcps_pkg::EARLY_WINDOW)) begin
          if (t > state.current_check_deadline) begin
            state_nxt.phase = bcps_pkg::PH_ENDPOINT;
          end
        end else if (t >= state.didt_deadline) begin
          if (didt_rise > 18'sd50) begin
            state_nxt.didt_fault = 1'b1;
            state_nxt.phase      = bcps_pkg::PH_ENDPOINT;
          end else begin
            if (ibat_ext < state.didt_lowest_current) begin
              state_nxt.didt_lowest_current = ibat_ext;
            end
            state_nxt.didt_deadline = bcps_pkg::tadd(t,
                                      bcps_pkg::timer_t'(bcps_pkg::DIDT_PERIOD));
          end
        end else begin
          state_nxt.current_check_deadline = bcps_pkg::tadd(t,
                                             bcps_pkg::timer_t'(cfg.current_check_delay));
        end
      end
      bcps_pkg::PH_START3: begin
        state_nxt.phase3_deadline      = bcps_pkg::tadd(t,
                                         bcps_pkg::timer_t'(bcps_pkg::PH3_MAX_TIME));
        state_nxt.phase3_vreg_deadline = bcps_pkg::tadd(t,
                                         bcps_pkg::timer_t'(cfg.phase3_vreg_delay));
        if (div_quot < 11'(bcps_pkg::IPH3_MIN)) begin
          state_nxt.current_request = 16'(bcps_pkg::IPH3_MIN);
        end else begin
          state_nxt.current_request = 16'(div_quot);
        end
        state_nxt.phase = bcps_pkg::PH_PH3;
      end
      bcps_pkg::PH_PH3: begin
        if (t > state.phase3_vreg_deadline) begin
          state_nxt.voltage_request = 12'(bcps_pkg::VREQ_PH3);
        end
        if (t > state.phase3_deadline) begin
          state_nxt.phase = bcps_pkg::PH_ENDPOINT;
        end
      end
      bcps_pkg::PH_ENDPOINT: begin
        state_nxt.phase        = bcps_pkg::PH_AVAIL;
        state_nxt.refresh_mark = t;
      end
      bcps_pkg::PH_AVAIL: begin
        if (word.filtered_cell_voltage < 12'(bcps_pkg::VAVAIL_LOW)) begin
          if (t > bcps_pkg::tadd(state.refresh_mark,
                                 bcps_pkg::timer_t'(bcps_pkg::REFRESH_WAIT))) begin
            state_nxt.phase = bcps_pkg::PH_STARTCOMP;
          end
        end else begin
          state_nxt.refresh_mark = t;
        end
      end
      bcps_pkg::PH_STARTCOMP: begin
        state_nxt.phase1_deadline = bcps_pkg::tadd(t,
                                    bcps_pkg::timer_t'(bcps_pkg::COMP_MAX_TIME));
        state_nxt.current_request = 16'(state.phase1_current);
        state_nxt.gassing_voltage = bcps_pkg::gas_level(cfg.comp_temp);
        state_nxt.voltage_request = bcps_pkg::gas_level(cfg.comp_temp);
        state_nxt.phase           = bcps_pkg::PH_COMP;
        state_nxt.refresh_mark    = t;
      end
      bcps_pkg::PH_COMP: begin
        if (t > state.phase1_deadline) begin
          state_nxt.phase = bcps_pkg::PH_ENDPOINT;
        end else if (ibat_ext < $signed({1'b0, cfg.comp_min_current})) begin
          if (t > bcps_pkg::tadd(state.refresh_mark,
                                 bcps_pkg::timer_t'(bcps_pkg::REFRESH_WAIT))) begin
            state_nxt.phase = bcps_pkg::PH_ENDPOINT;
          end
        end else begin
          state_nxt.refresh_mark = t;
        end
      end
      default: begin
        // unused phase codes hold everything
        state_nxt = state;
      end
    endcase
  end

endmodule

// ===== sv/battery_charge_profile_sequencer.sv =====
// Charge profile sequencer: one charger tick is taken per clock cycle whenever the
// result register is empty or being drained (in_ready = !out_valid || out_ready), so
// ticks can stream back to back; the result of a tick appears in the output register
// on the next cycle. The rate is set by the combinational profile state update in
// bcps_step, which reads the state registers and the incoming word and writes both the
// state and the result register at the same edge. Configuration writes take effect at
// once and should be made while no tick is in flight.
// top level; depends on bcps_pkg, bcps_step and assert_macros.svh
`include "assert_macros.svh"

module battery_charge_profile_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bcps_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bcps_pkg::out_word_t  out_data,
  input  logic                 cfg_we,
  input  bcps_pkg::cfg_idx_t   cfg_index,
  input  logic [15:0]          cfg_wdata
);

  bcps_pkg::cfg_t      cfg_r;
  bcps_pkg::state_t    state_r;
  bcps_pkg::state_t    state_nxt;
  bcps_pkg::out_word_t out_r;
  logic                out_valid_r;
  logic                in_fire;
  logic                any_fault;
  logic                charge_over;
  logic                ph3_low;
  logic                tmo_set;
  logic                tmo_held;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bat_capacity        <= 12'd100;
      cfg_r.max_current         <= 16'd1000;
      cfg_r.start_temp          <= 8'sd25;
      cfg_r.comp_temp           <= 8'sd25;
      cfg_r.vbat_check_delay    <= 16'd60;
      cfg_r.current_check_delay <= 16'd60;
      cfg_r.phase3_vreg_delay   <= 16'd60;
      cfg_r.comp_min_current    <= 16'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcps_pkg::CFG_BAT_CAPACITY:        cfg_r.bat_capacity        <= cfg_wdata[11:0];
        bcps_pkg::CFG_MAX_CURRENT:         cfg_r.max_current         <= cfg_wdata;
        bcps_pkg::CFG_START_TEMP:          cfg_r.start_temp          <= $signed(cfg_wdata[7:0]);
        bcps_pkg::CFG_COMP_TEMP:           cfg_r.comp_temp           <= $signed(cfg_wdata[7:0]);
        bcps_pkg::CFG_VBAT_CHECK_DELAY:    cfg_r.vbat_check_delay    <= cfg_wdata;
        bcps_pkg::CFG_CURRENT_CHECK_DELAY: cfg_r.current_check_delay <= cfg_wdata;
        bcps_pkg::CFG_PHASE3_VREG_DELAY:   cfg_r.phase3_vreg_delay   <= cfg_wdata;
        bcps_pkg::CFG_COMP_MIN_CURRENT:    cfg_r.comp_min_current    <= cfg_wdata;
      endcase
    end
  end

  // profile next state
  bcps_step u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .word      (in_data),
    .state_nxt (state_nxt)
  );

  // profile state, all cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r.current_request <= state_nxt.current_request;
      out_r.voltage_request <= state_nxt.voltage_request;
      out_r.phase           <= state_nxt.phase;
      out_r.timeout_fault   <= state_nxt.timeout_fault;
      out_r.didt_fault      <= state_nxt.didt_fault;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  assign any_fault   = state_r.timeout_fault || state_r.didt_fault;
  assign charge_over = (state_r.phase == bcps_pkg::PH_ENDPOINT) ||
                       (state_r.phase == bcps_pkg::PH_AVAIL) ||
                       (state_r.phase == bcps_pkg::PH_STARTCOMP) ||
                       (state_r.phase == bcps_pkg::PH_COMP);
  assign ph3_low     = (state_r.phase == bcps_pkg::PH_PH3) &&
                       (state_r.current_request < 16'(bcps_pkg::IPH3_MIN));
  assign tmo_set     = rst_n && state_r.timeout_fault;
  assign tmo_held    = !rst_n || state_r.timeout_fault;

  `BCPS_ASSERT(a_fire_gives_word, in_fire |=> out_valid_r, "accepted tick gave no result word")
  `BCPS_ASSERT(a_fault_ends_charge, any_fault |-> charge_over, "fault seen while charging")
  `BCPS_ASSERT(a_ph3_floor, !ph3_low, "phase 3 current below floor")
  `BCPS_ASSERT_ALWAYS(a_fault_sticky, tmo_set |=> tmo_held, "timeout fault cleared")

endmodule

// ===== bench/tb_battery_charge_profile_sequencer.sv =====
`timescale 1ns / 1ps
// self-checking bench for the charge profile sequencer: a profile predictor in a small
// scoreboard class, bursty tick words in and a stalling receiver on the result words
// depends on bcps_pkg and battery_charge_profile_sequencer
module tb_battery_charge_profile_sequencer;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  // predicts the request word of every tick and checks the block against it
  class charge_profile_checker;
    // register copies
    logic [11:0]        bat_capacity;
    logic [15:0]        max_current;
    logic signed [7:0]  start_temp;
    logic signed [7:0]  comp_temp;
    logic [15:0]        vbat_check_delay;
    logic [15:0]        current_check_delay;
    logic [15:0]        phase3_vreg_delay;
    logic [15:0]        comp_min_current;
    // profile state
    bcps_pkg::phase_t   phase;
    logic [15:0]        ph1_current;
    logic [11:0]        gas_v;
    bcps_pkg::timer_t   ph1_dl, ph2_dl, ph3_dl, vbat_dl;
    bcps_pkg::timer_t   cur_dl, vreg_dl, didt_dl, refresh_t;
    int                 didt_low;
    logic [15:0]        i_req;
    logic [11:0]        v_req;
    bit                 tmo_flag, didt_flag;
    // bookkeeping
    bcps_pkg::out_word_t expected_requests[$];
    int                 mismatches, ticks, checked;
    bit [15:0]          phases_seen;

    function new();
      bat_capacity = 12'd100;
      max_current = 16'd1000;
      start_temp = 8'sd25;
      comp_temp = 8'sd25;
      vbat_check_delay = 16'd60;
      current_check_delay = 16'd60;
      phase3_vreg_delay = 16'd60;
      comp_min_current = 16'd10;
      phase = bcps_pkg::PH_START1;
      ph1_current = '0;
      gas_v = '0;
      ph1_dl = '0; ph2_dl = '0; ph3_dl = '0; vbat_dl = '0;
      cur_dl = '0; vreg_dl = '0; didt_dl = '0; refresh_t = '0;
      didt_low = 0;
      i_req = '0;
      v_req = '0;
      tmo_flag = 1'b0;
      didt_flag = 1'b0;
      mismatches = 0;
      ticks = 0;
      checked = 0;
      phases_seen = '0;
    endfunction

    function void set_reg(bcps_pkg::cfg_idx_t idx, logic [15:0] v);
      case (idx)
        bcps_pkg::CFG_BAT_CAPACITY:        bat_capacity = v[11:0];
        bcps_pkg::CFG_MAX_CURRENT:         max_current = v;
        bcps_pkg::CFG_START_TEMP:          start_temp = v[7:0];
        bcps_pkg::CFG_COMP_TEMP:           comp_temp = v[7:0];
        bcps_pkg::CFG_VBAT_CHECK_DELAY:    vbat_check_delay = v;
        bcps_pkg::CFG_CURRENT_CHECK_DELAY: current_check_delay = v;
        bcps_pkg::CFG_PHASE3_VREG_DELAY:   phase3_vreg_delay = v;
        bcps_pkg::CFG_COMP_MIN_CURRENT:    comp_min_current = v;
        default: ;
      endcase
    endfunction

    // gassing level falls 4 mV per degree, clamped to its band
    function logic [11:0] gassing_for(logic signed [7:0] temp);
      int v;
      v = bcps_pkg::VGAS_BASE - int'(temp) * 4;
      if (v > bcps_pkg::VGAS_MAX) v = bcps_pkg::VGAS_MAX;
      else if (v < bcps_pkg::VGAS_MIN) v = bcps_pkg::VGAS_MIN;
      return v[11:0];
    endfunction

    function int pending();
      return expected_requests.size();
    endfunction

    // advance the profile by one accepted tick and queue the request word it yields
    function void note_tick(bcps_pkg::in_word_t w);
      bcps_pkg::timer_t    t;
      bcps_pkg::timer_t    wait_end;
      int                  ibat;
      int unsigned         i;
      bcps_pkg::out_word_t e;
      t = bcps_pkg::timer_t'(w.charge_seconds);
      ibat = int'(w.battery_current);
      wait_end = refresh_t + bcps_pkg::REFRESH_WAIT;
      case (phase)
        bcps_pkg::PH_START1: begin
          i = 32'(bat_capacity) * 5;
          if (i < bcps_pkg::IPH1_MIN) i = bcps_pkg::IPH1_MIN;
          else if (i > max_current) i = 32'(max_current);
          if (i > bcps_pkg::CMAX) i = bcps_pkg::CMAX;
          ph1_current = i[15:0];
          gas_v = gassing_for(start_temp);
          ph1_dl = t + bcps_pkg::PH1_MAX_TIME;
          i_req = ph1_current;
          v_req = 12'(bcps_pkg::VREQ_PH1);
          vbat_dl = t + vbat_check_delay;
          phase = bcps_pkg::PH_PH1;
        end
        bcps_pkg::PH_PH1: begin
          if (t > ph1_dl) begin
            tmo_flag = 1'b1;
            phase = bcps_pkg::PH_ENDPOINT;
          end else if (w.cell_voltage >= gas_v) begin
            if (vbat_dl < t) phase = bcps_pkg::PH_START2;
          end else begin
            vbat_dl = t + vbat_check_delay;
          end
        end
        bcps_pkg::PH_START2: begin
          ph2_dl = t + bcps_pkg::PH2_MAX_TIME;
          didt_dl = t + bcps_pkg::DIDT_PERIOD;
          didt_low = int'(max_current);
          i_req = (ph1_current != 0) ? ph1_current - 1'b1 : 16'd0;
          v_req = gas_v;
          cur_dl = t + current_check_delay;
          phase = bcps_pkg::PH_PH2;
        end
        bcps_pkg::PH_PH2: begin
          if (t > ph2_dl) begin
            phase = bcps_pkg::PH_START3;
          end else if (ibat <= bcps_pkg::LOW_CURRENT && t < bcps_pkg::EARLY_WINDOW) begin
            if (t > cur_dl) phase = bcps_pkg::PH_ENDPOINT;
          end else if (t >= didt_dl) begin
            // current rising again over the window means a failing cell
            if (ibat - didt_low > bcps_pkg::DIDT_THRESHOLD) begin
              didt_flag = 1'b1;
              phase = bcps_pkg::PH_ENDPOINT;
            end else begin
              if (ibat < didt_low) didt_low = ibat;
              didt_dl = t + bcps_pkg::DIDT_PERIOD;
            end
          end else begin
            cur_dl = t + current_check_delay;
          end
        end
        bcps_pkg::PH_START3: begin
          ph3_dl = t + bcps_pkg::PH3_MAX_TIME;
          vreg_dl = t + phase3_vreg_delay;
          i = 32'(ph1_current) / 50;
          i_req = (i < bcps_pkg::IPH3_MIN) ? 16'(bcps_pkg::IPH3_MIN) : i[15:0];
          phase = bcps_pkg::PH_PH3;
        end
        bcps_pkg::PH_PH3: begin
          if (t > vreg_dl) v_req = 12'(bcps_pkg::VREQ_PH3);
          if (t > ph3_dl) phase = bcps_pkg::PH_ENDPOINT;
        end
        bcps_pkg::PH_ENDPOINT: begin
          phase = bcps_pkg::PH_AVAIL;
          refresh_t = t;
        end
        bcps_pkg::PH_AVAIL: begin
          if (w.filtered_cell_voltage < bcps_pkg::VAVAIL_LOW) begin
            if (t > wait_end) phase = bcps_pkg::PH_STARTCOMP;
          end else begin
            refresh_t = t;
          end
        end
        bcps_pkg::PH_STARTCOMP: begin
          ph1_dl = t + bcps_pkg::COMP_MAX_TIME;
          i_req = ph1_current;
          gas_v = gassing_for(comp_temp);
          v_req = gas_v;
          phase = bcps_pkg::PH_COMP;
          refresh_t = t;
        end
        bcps_pkg::PH_COMP: begin
          if (t > ph1_dl) begin
            phase = bcps_pkg::PH_ENDPOINT;
          end else if (ibat < int'(comp_min_current)) begin
            if (t > wait_end) phase = bcps_pkg::PH_ENDPOINT;
          end else begin
            refresh_t = t;
          end
        end
        default: ;
      endcase
      e.current_request = i_req;
      e.voltage_request = v_req;
      e.phase = phase;
      e.timeout_fault = tmo_flag;
      e.didt_fault = didt_flag;
      expected_requests.push_back(e);
      phases_seen[phase] = 1'b1;
      ticks++;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch at word %0d: %s got %0d, expected %0d",
               $time, checked, what, got, want);
      mismatches++;
    endtask

    task check_request(bcps_pkg::out_word_t got);
      bcps_pkg::out_word_t e;
      if (expected_requests.size() == 0) begin
        report_mismatch("word with no tick outstanding", 32'(got.phase), 32'd0);
        return;
      end
      e = expected_requests.pop_front();
      if (got.current_request !== e.current_request)
        report_mismatch("current_request", 32'(got.current_request),
                        32'(e.current_request));
      if (got.voltage_request !== e.voltage_request)
        report_mismatch("voltage_request", 32'(got.voltage_request),
                        32'(e.voltage_request));
      if (got.phase !== e.phase)
        report_mismatch("phase", 32'(got.phase), 32'(e.phase));
      if (got.timeout_fault !== e.timeout_fault)
        report_mismatch("timeout_fault", 32'(got.timeout_fault), 32'(e.timeout_fault));
      if (got.didt_fault !== e.didt_fault)
        report_mismatch("didt_fault", 32'(got.didt_fault), 32'(e.didt_fault));
      checked++;
    endtask

    task close_out();
      if (expected_requests.size() != 0)
        report_mismatch("words never returned", 32'(expected_requests.size()), 32'd0);
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  bcps_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  bcps_pkg::out_word_t out_data;
  logic                cfg_we = 1'b0;
  bcps_pkg::cfg_idx_t  cfg_index = bcps_pkg::CFG_BAT_CAPACITY;
  logic [15:0]         cfg_wdata = '0;

  charge_profile_checker sb;
  logic [31:0] now_s;
  int          burst_left = 0;
  int          reg_writes = 0;
  int          rx_cycle = 0;
  int          rx_period = 3;
  rx_mode_t    rx_mode = RX_OPEN;

  battery_charge_profile_sequencer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // guard against a hung handshake
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver: switches between open, random and periodic stalls
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 257 == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_period = $urandom_range(2, 7);
    end
    case (rx_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_RANDOM:   out_ready <= ($urandom_range(0, 99) < 60);
      default:     out_ready <= (rx_cycle % rx_period) != 0;
    endcase
  end

  // result word monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_request(out_data);
  end

  function automatic logic [15:0] as_current(int v);
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // register values lean toward the extremes; upper bits beyond a register's width vary
  function automatic logic [15:0] pick_reg_value(bcps_pkg::cfg_idx_t idx);
    int unsigned r;
    r = $urandom_range(0, 9);
    case (idx)
      bcps_pkg::CFG_BAT_CAPACITY:
        return {4'($urandom), (r < 2) ? 12'd1 : (r < 4) ? 12'd4095 : (r < 5) ? 12'd0 :
                12'($urandom_range(1, 400))};
      bcps_pkg::CFG_MAX_CURRENT:
        return (r < 2) ? 16'($urandom_range(0, 60)) : (r < 3) ? 16'hFFFF :
               (r < 4) ? 16'd0 : 16'($urandom_range(50, 3000));
      bcps_pkg::CFG_START_TEMP, bcps_pkg::CFG_COMP_TEMP:
        return {8'($urandom), (r < 2) ? 8'h80 : (r < 3) ? 8'h7F : 8'($urandom)};
      bcps_pkg::CFG_COMP_MIN_CURRENT:
        return (r < 2) ? 16'd0 : (r < 3) ? 16'hFFFF : 16'($urandom_range(0, 200));
      default:
        return (r < 2) ? 16'd0 : (r < 3) ? 16'hFFFF : (r < 4) ? 16'd60 :
               16'($urandom_range(0, 600));
    endcase
  endfunction

  // next tick: timer mostly runs forward, fields mostly steer the current phase onward
  function automatic bcps_pkg::in_word_t make_tick();
    bcps_pkg::in_word_t w;
    int unsigned        roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) now_s += $urandom_range(1, 60);
    else if (roll < 97) now_s += $urandom_range(60, 1500);
    else if (sb.phase >= bcps_pkg::PH_ENDPOINT)
      now_s = (roll == 99) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 300);
    else now_s += $urandom_range(1, 5);
    w.charge_seconds = now_s;
    w.cell_voltage = 12'($urandom_range(0, 4095));
    w.filtered_cell_voltage = 12'($urandom_range(0, 4095));
    w.battery_current = 16'($urandom);
    roll = $urandom_range(0, 99);
    // a few words stay pure noise
    if (roll >= 8) begin
      case (sb.phase)
        bcps_pkg::PH_PH1:
          if (roll < 80) w.cell_voltage = 12'($urandom_range(sb.gas_v, sb.gas_v + 200));
        bcps_pkg::PH_PH2:
          if (roll < 35)
            w.battery_current = as_current(int'($urandom_range(0, 120)) - 100);
          else if (roll < 75)
            w.battery_current = as_current(sb.didt_low - 30 + int'($urandom_range(0, 75)));
          else if (roll < 85)
            w.battery_current = as_current(sb.didt_low + 51 + int'($urandom_range(0, 100)));
        bcps_pkg::PH_AVAIL:
          if (roll < 75)
            w.filtered_cell_voltage = 12'($urandom_range(0, bcps_pkg::VAVAIL_LOW - 1));
        bcps_pkg::PH_COMP:
          if (roll < 70)
            w.battery_current = as_current(int'(sb.comp_min_current) - 1 -
                                           int'($urandom_range(0, 50)));
        default: ;
      endcase
    end
    return w;
  endfunction

  // sender: bursts of words with random gaps
  task automatic push_tick(input bcps_pkg::in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(w);
    burst_left--;
  endtask

  task automatic push_fields(input logic [11:0] cv, input logic [11:0] fv,
                             input logic [15:0] ib);
    bcps_pkg::in_word_t w;
    now_s += 1;
    w.charge_seconds = now_s;
    w.cell_voltage = cv;
    w.filtered_cell_voltage = fv;
    w.battery_current = ib;
    push_tick(w);
  endtask

  // stop sending and let every outstanding word drain
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] mask);
    logic [15:0]        v;
    bcps_pkg::cfg_idx_t idx;
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) begin
        idx = bcps_pkg::cfg_idx_t'(i);
        v = pick_reg_value(idx);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
        reg_writes++;
      end
    end
    cfg_we <= 1'b0;
  endtask

  // main sequence
  initial begin
    int unsigned r;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    program_regs(8'hFF);

    // timer start: from zero for the early window, elsewhere, or just below the wrap
    r = $urandom_range(0, 9);
    if (r < 5) now_s = 0;
    else if (r < 9) now_s = $urandom_range(0, 100000);
    else now_s = 32'hFFFF_FFFF - $urandom_range(0, 20000);

    // field extremes and values around the thresholds
    push_fields(12'd0, 12'd0, 16'd0);
    push_fields(12'd4095, 12'd4095, 16'h7FFF);
    push_fields(12'd0, 12'd4095, 16'h8000);
    push_fields(12'd4095, 12'd0, 16'hFFFF);
    push_fields(12'd2500, 12'd2150, 16'd20);
    push_fields(12'd2320, 12'd2149, 16'd21);
    push_fields(12'd2319, 12'd2151, 16'd19);
    push_fields(12'd2501, 12'd1, 16'hFFF6);

    // random profile walk with register changes between stretches
    for (int n = 0; n < 1300; n++) begin
      if (n > 0 && n % 200 == 0) begin
        settle();
        program_regs(8'($urandom_range(1, 255)));
      end
      push_tick(make_tick());
    end
    settle();
    sb.close_out();

    $display("Summary: %0d ticks sent, %0d result words compared, %0d register writes",
             sb.ticks, sb.checked, reg_writes);
    $display("Summary: phases reached %b, timeout fault %0b, dI/dt fault %0b",
             sb.phases_seen[9:0], sb.tmo_flag, sb.didt_flag);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== battery_charge_profile_sequencer.f =====
+incdir+sv
sv/bcps_pkg.sv
sv/bcps_step.sv
sv/battery_charge_profile_sequencer.sv
bench/tb_battery_charge_profile_sequencer.sv
